[rtl/core/stepper_axis_limit_homing_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the stepper axis core
// Concurrent checks on clk, disabled while rst_n is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef STEPPER_AXIS_LIMIT_HOMING_CORE_ASSERT_SVH
`define STEPPER_AXIS_LIMIT_HOMING_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SALH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SALH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SALH_ASSERT_NOW(lbl, ante, cons, msg)
`define SALH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/salh_pkg.sv]
// ----------------------------------------------------------------------------
// salh_pkg
// Types and constants shared by the stepper axis controller and its top level.
// ----------------------------------------------------------------------------
package salh_pkg;

  // request kinds carried on in_tuser
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_REL  = 2'd1;
  localparam logic [1:0] MODE_ABS  = 2'd2;
  localparam logic [1:0] MODE_HOME = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_SOFT_MIN     = 2'd0;
  localparam logic [1:0] REG_SOFT_MAX     = 2'd1;
  localparam logic [1:0] REG_HOME_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_BACKOFF      = 2'd3;

  // register reset values
  localparam logic signed [15:0] SOFT_MIN_RST     = -16'sd2100;
  localparam logic signed [15:0] SOFT_MAX_RST     = 16'sd2100;
  localparam logic [15:0]        HOME_TIMEOUT_RST = 16'd20000;
  localparam logic [7:0]         BACKOFF_RST      = 8'd50;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 56;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_MOVE   = 3'd1,
    PH_SEEKN  = 3'd2,
    PH_BACK   = 3'd3,
    PH_SEEKP  = 3'd4,
    PH_CENTER = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic signed [16:0] pos;
    logic [16:0]        remaining;
    logic [16:0]        taken;
    logic               dir;
    logic               homed;
    logic [15:0]        seek;
    logic [15:0]        range;
    logic               herr;
  } salh_state_t;

  typedef struct packed {
    logic signed [15:0] soft_min;
    logic signed [15:0] soft_max;
    logic [15:0]        home_timeout;
    logic [7:0]         backoff;
  } salh_cfg_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [16:0] value;
    logic               neg_limit;
    logic               pos_limit;
  } salh_item_t;

  typedef struct packed {
    logic               step;
    logic               direction;
    logic signed [16:0] position;
    logic               busy_res;
    logic               done_res;
    logic signed [16:0] moved;
    logic               homed;
    logic               home_error;
    logic [15:0]        travel_range;
    logic               rejected;
  } salh_result_t;

endpackage

[rtl/core/salh_ctrl.sv]
// ----------------------------------------------------------------------------
// salh_ctrl
// One-pass next-state and result logic for a single request: command decode,
// move stepping with limit and soft-window stops, and the homing sequence.
// ----------------------------------------------------------------------------
module salh_ctrl
  import salh_pkg::*;
(
  input  salh_state_t  st,
  input  salh_cfg_t    cfg,
  input  salh_item_t   item,
  output salh_state_t  st_nxt,
  output salh_result_t res
);

  logic signed [17:0] delta;
  logic [16:0]        delta_abs;
  logic signed [17:0] next_pos;
  logic               move_stop;
  logic               step_ok;
  logic [16:0]        rem_dec;
  logic [16:0]        taken_inc;
  logic               seek_limit;
  logic               step_w;
  logic               done_w;
  logic               rej_w;
  logic signed [16:0] moved_w;
  salh_state_t        ns;

  // requested travel and its magnitude
  always_comb begin
    if (item.mode == MODE_REL) begin
      delta = {item.value[16], item.value};
    end else begin
      delta = {item.value[16], item.value} - {st.pos[16], st.pos};
    end
    delta_abs = delta[17] ? 17'(-delta) : delta[16:0];
  end

  // move step check against limits and the soft window
  always_comb begin
    next_pos  = st.dir ? ({st.pos[16], st.pos} + 18'sd1) : ({st.pos[16], st.pos} - 18'sd1);
    move_stop = (st.dir && item.pos_limit) || (!st.dir && item.neg_limit) ||
                (next_pos < $signed({{2{cfg.soft_min[15]}}, cfg.soft_min})) ||
                (next_pos > $signed({{2{cfg.soft_max[15]}}, cfg.soft_max}));
    step_ok    = !move_stop;
    rem_dec    = st.remaining - 17'd1;
    taken_inc  = st.taken + 17'd1;
    seek_limit = (st.phase == PH_SEEKN) ? item.neg_limit : item.pos_limit;
  end

  always_comb begin
    ns      = st;
    step_w  = 1'b0;
    done_w  = 1'b0;
    rej_w   = 1'b0;
    moved_w = '0;
    if (item.mode != MODE_TICK) begin
      // command request
      if (st.phase != PH_IDLE) begin
        rej_w = 1'b1;
      end else begin
        case (item.mode) inside
          MODE_HOME: begin
            ns.herr  = 1'b0;
            ns.seek  = '0;
            ns.dir   = 1'b0;
            ns.phase = PH_SEEKN;
          end
          MODE_REL, MODE_ABS: begin
            ns.dir       = !delta[17] && (delta != '0);
            ns.remaining = delta_abs;
            ns.taken     = '0;
            if (delta_abs == '0) begin
              done_w = 1'b1;
            end else begin
              ns.phase = PH_MOVE;
            end
          end
          default: ;
        endcase
      end
    end else begin
      // tick request
      unique case (st.phase)
        PH_MOVE: begin
          if (step_ok) begin
            step_w       = 1'b1;
            ns.pos       = next_pos[16:0];
            ns.taken     = taken_inc;
            ns.remaining = rem_dec;
          end
          if (move_stop || (rem_dec == '0)) begin
            done_w   = 1'b1;
            moved_w  = st.dir ? ns.taken : 17'(-ns.taken);
            ns.phase = PH_IDLE;
          end
        end
        PH_SEEKN, PH_SEEKP: begin
          if (st.seek >= cfg.home_timeout) begin
            ns.herr  = 1'b1;
            done_w   = 1'b1;
            ns.phase = PH_IDLE;
          end else if (seek_limit) begin
            if (st.phase == PH_SEEKN) begin
              ns.dir       = 1'b1;
              ns.seek      = '0;
              ns.remaining = {9'd0, cfg.backoff};
              ns.phase     = (cfg.backoff != '0) ? PH_BACK : PH_SEEKP;
            end else begin
              ns.range     = st.seek;
              ns.remaining = {2'b00, st.seek[15:1]};
              ns.dir       = 1'b0;
              if (st.seek[15:1] == '0) begin
                ns.pos   = '0;
                ns.homed = 1'b1;
                ns.phase = PH_IDLE;
                done_w   = 1'b1;
              end else begin
                ns.phase = PH_CENTER;
              end
            end
          end else begin
            step_w  = 1'b1;
            ns.seek = st.seek + 16'd1;
          end
        end
        PH_BACK: begin
          step_w       = 1'b1;
          ns.remaining = rem_dec;
          if (rem_dec == '0) begin
            ns.seek  = '0;
            ns.phase = PH_SEEKP;
          end
        end
        PH_CENTER: begin
          step_w       = 1'b1;
          ns.remaining = rem_dec;
          if (rem_dec == '0) begin
            ns.pos   = '0;
            ns.homed = 1'b1;
            ns.phase = PH_IDLE;
            done_w   = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // drive the result from the updated state
  always_comb begin
    st_nxt           = ns;
    res.step         = step_w;
    res.direction    = ns.dir;
    res.position     = ns.pos;
    res.busy_res     = (ns.phase != PH_IDLE);
    res.done_res     = done_w;
    res.moved        = moved_w;
    res.homed        = ns.homed;
    res.home_error   = ns.herr;
    res.travel_range = ns.range;
    res.rejected     = rej_w;
  end

endmodule

[rtl/core/stepper_axis_limit_homing_core.sv]
// ----------------------------------------------------------------------------
// stepper_axis_limit_homing_core
// Single-axis stepper controller with moves, limit switches and homing.
// ----------------------------------------------------------------------------
// Takes one request per clock while in_tready is high: each accepted request
// updates the axis state in a single combinational pass and lands in the result
// register on the same edge.
// in_tready is high whenever the result register is empty or is being taken
// in the same cycle. Requests on in_tuser: tick, relative move, absolute move,
// start homing. Each request yields exactly one result; out_tlast marks the
// result on which a move or homing sequence finished. Configuration writes
// take effect at the next edge and belong to idle periods.
// ----------------------------------------------------------------------------
`include "stepper_axis_limit_homing_core_assert.svh"

module stepper_axis_limit_homing_core
  import salh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_wdata,
  // request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // in_tdata: value[16:0], neg_limit[17], pos_limit[18], zero fill [23:19]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: mode[1:0]
  input  logic [1:0]            in_tuser,
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata: step[0], direction[1], position[18:2], busy_res[19],
  //   moved[36:20], homed[37], home_error[38], travel_range[54:39], rejected[55]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tlast: done_res
  output logic                  out_tlast
);

  salh_state_t  st_r;
  salh_state_t  st_nxt;
  salh_cfg_t    cfg_r;
  salh_item_t   item;
  salh_result_t res;
  logic         in_acc;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // unpack the request
  always_comb begin
    item.mode      = in_tuser;
    item.value     = in_tdata[16:0];
    item.neg_limit = in_tdata[17];
    item.pos_limit = in_tdata[18];
  end

  salh_ctrl u_ctrl (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (item),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.soft_min     <= SOFT_MIN_RST;
      cfg_r.soft_max     <= SOFT_MAX_RST;
      cfg_r.home_timeout <= HOME_TIMEOUT_RST;
      cfg_r.backoff      <= BACKOFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOFT_MIN:     cfg_r.soft_min     <= cfg_wdata;
        REG_SOFT_MAX:     cfg_r.soft_max     <= cfg_wdata;
        REG_HOME_TIMEOUT: cfg_r.home_timeout <= cfg_wdata;
        REG_BACKOFF:      cfg_r.backoff      <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // axis state: advance on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase     <= PH_IDLE;
      st_r.pos       <= '0;
      st_r.remaining <= '0;
      st_r.taken     <= '0;
      st_r.dir       <= 1'b0;
      st_r.homed     <= 1'b0;
      st_r.seek      <= '0;
      st_r.range     <= '0;
      st_r.herr      <= 1'b0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  // result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= {res.rejected, res.travel_range, res.home_error, res.homed,
                     res.moved, res.busy_res, res.position, res.direction, res.step};
      out_last_r <= res.done_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // position stays frozen while homing continues
  `SALH_ASSERT_NEXT(a_home_pos_frozen,
    in_acc && (st_r.phase == PH_SEEKN || st_r.phase == PH_BACK ||
      st_r.phase == PH_SEEKP || st_r.phase == PH_CENTER) &&
      (st_nxt.phase != PH_IDLE), st_r.pos == $past(st_r.pos),
    "axis position changed during homing")
  // a step is only issued while a motion is in progress
  `SALH_ASSERT_NOW(a_step_needs_busy, in_acc && res.step, st_r.phase != PH_IDLE,
    "step issued while idle")
  // a finished request leaves the block idle
  `SALH_ASSERT_NOW(a_done_goes_idle, in_acc && res.done_res, st_nxt.phase == PH_IDLE,
    "done reported but phase not idle")
  // rejections only happen while busy and never move the state
  `SALH_ASSERT_NOW(a_reject_when_busy, in_acc && res.rejected,
    (st_r.phase != PH_IDLE) && (st_nxt == st_r), "command rejected while idle")

endmodule
